// ----- src/egsa_pkg.sv -----
`default_nettype none
package egsa_pkg;

  // configuration port
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 7;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANS_IN_USE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEQ_LEN = 1'd1;
  localparam logic [CFG_DATA_W-1:0] CFG_RESET_VAL = 7'd64;

  // result status codes
  localparam logic [1:0] STATUS_OK = 2'd0;
  localparam logic [1:0] STATUS_SKIP = 2'd1;
  localparam logic [1:0] STATUS_POS_RANGE = 2'd2;
  localparam logic [1:0] STATUS_SAT = 2'd3;

  // classification of one request, front to back
  typedef struct packed {
    logic skip;
    logic pos_bad;
    logic last;
  } egsa_cls_t;

endpackage
`default_nettype wire

// ----- src/egsa_if.sv -----
`default_nettype none
interface egsa_item_if;
  logic valid;
  logic ready;
  logic [7:0] token_id;
  logic [5:0] position;
  logic [5:0] channel;
  logic signed [31:0] grad;
  logic last_item;

  modport source(output valid, token_id, position, channel, grad, last_item, input ready);
  modport sink(input valid, token_id, position, channel, grad, last_item, output ready);
endinterface

interface egsa_result_if;
  logic valid;
  logic ready;
  logic signed [31:0] token_grad_now;
  logic signed [31:0] pos_grad_now;
  logic [1:0] status;
  logic done_res;

  modport source(output valid, token_grad_now, pos_grad_now, status, done_res, input ready);
  modport sink(input valid, token_grad_now, pos_grad_now, status, done_res, output ready);
endinterface
`default_nettype wire

// ----- src/egsa_front.sv -----
`default_nettype none
module egsa_front #(
  parameter int VOCAB_ROWS = 256,
  parameter int MAX_POSITIONS = 64,
  parameter int MAX_CHANNELS = 64,
  parameter int TA_W = 14,
  parameter int PA_W = 12
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_we,
  input  wire logic [egsa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [egsa_pkg::CFG_DATA_W-1:0] cfg_data,
  egsa_item_if.sink item,
  input  wire logic q_full,
  input  wire logic clearing,
  output logic push,
  output egsa_pkg::egsa_cls_t cls,
  output logic [TA_W-1:0] tok_addr,
  output logic [PA_W-1:0] pos_addr,
  output logic [31:0] grad
);

  localparam int TOK_W = $clog2(VOCAB_ROWS);

  logic [egsa_pkg::CFG_DATA_W-1:0] chans_in_use;
  logic [egsa_pkg::CFG_DATA_W-1:0] seq_len;
  logic [TOK_W-1:0] wrap_lut [256];
  logic [TOK_W-1:0] tok_row;
  logic chan_ok;
  logic pos_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      chans_in_use <= egsa_pkg::CFG_RESET_VAL;
      seq_len <= egsa_pkg::CFG_RESET_VAL;
    end else if (cfg_we) begin
      case (cfg_index)
        egsa_pkg::CFG_CHANS_IN_USE: chans_in_use <= cfg_data;
        egsa_pkg::CFG_SEQ_LEN: seq_len <= cfg_data;
        default: ;
      endcase
    end
  end

  // token id wraps modulo the vocabulary size
  for (genvar g = 0; g < 256; g++) begin : g_wrap
    assign wrap_lut[g] = TOK_W'(g % VOCAB_ROWS);
  end

  assign tok_row = wrap_lut[item.token_id];
  assign chan_ok = (7'(item.channel) < chans_in_use) && (int'(item.channel) < MAX_CHANNELS);
  assign pos_ok = (7'(item.position) < seq_len) && (int'(item.position) < MAX_POSITIONS);

  assign item.ready = !q_full && !clearing;
  assign push = item.valid && item.ready;

  assign cls.skip = !chan_ok;
  assign cls.pos_bad = chan_ok && !pos_ok;
  assign cls.last = item.last_item;
  assign tok_addr = TA_W'(int'(tok_row) * MAX_CHANNELS + int'(item.channel));
  assign pos_addr = PA_W'(int'(item.position) * MAX_CHANNELS + int'(item.channel));
  assign grad = item.grad;

endmodule
`default_nettype wire

// ----- src/egsa_queue.sv -----
`default_nettype none
module egsa_queue #(
  parameter int W = 8
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire logic [W-1:0] wdata,
  input  wire logic pop,
  output logic [W-1:0] rdata,
  output logic full,
  output logic not_empty
);

  logic [W-1:0] slot [2];
  logic wr_ptr;
  logic rd_ptr;
  logic [1:0] count;

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      if (push && !pop) count <= count + 2'd1;
      else if (pop && !push) count <= count - 2'd1;
    end
  end

  assign rdata = slot[rd_ptr];
  assign full = count == 2'd2;
  assign not_empty = count != 2'd0;

endmodule
`default_nettype wire

// ----- src/egsa_back.sv -----
`default_nettype none
module egsa_back #(
  parameter int TOK_DEPTH = 16384,
  parameter int POS_DEPTH = 4096,
  parameter int TA_W = 14,
  parameter int PA_W = 12
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic q_valid,
  input  wire egsa_pkg::egsa_cls_t q_cls,
  input  wire logic [TA_W-1:0] q_tok_addr,
  input  wire logic [PA_W-1:0] q_pos_addr,
  input  wire logic [31:0] q_grad,
  output logic pop,
  output logic clearing,
  egsa_result_if.source result
);

  localparam int CLR_DEPTH = TOK_DEPTH > POS_DEPTH ? TOK_DEPTH : POS_DEPTH;
  localparam int CLR_W = $clog2(CLR_DEPTH);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE = 2'd1;
  localparam logic [1:0] S_RUN = 2'd2;

  logic [31:0] tok_mem [TOK_DEPTH];
  logic [31:0] pos_mem [POS_DEPTH];

  logic [1:0] state;
  logic [1:0] state_next;
  logic [CLR_W-1:0] clr_cnt;
  logic clr_last;

  egsa_pkg::egsa_cls_t r_cls;
  logic [TA_W-1:0] r_tok_addr;
  logic [PA_W-1:0] r_pos_addr;
  logic [31:0] r_grad;

  logic [31:0] tok_rd;
  logic [31:0] pos_rd;
  logic fwd_tok;
  logic fwd_pos;
  logic [31:0] fwd_tok_val;
  logic [31:0] fwd_pos_val;

  logic out_free;
  logic finish;
  logic item_we;
  logic [31:0] tok_old;
  logic [31:0] pos_old;
  logic [32:0] tok_add;
  logic [32:0] pos_add;

  logic tok_we;
  logic pos_we;
  logic [TA_W-1:0] tok_wa;
  logic [PA_W-1:0] pos_wa;
  logic [31:0] tok_wd;
  logic [31:0] pos_wd;

  logic out_valid;
  logic [31:0] out_tok;
  logic [31:0] out_pos;
  logic [1:0] out_status;
  logic out_done;

  function automatic logic [32:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {a[31], a} + {b[31], b};
    if (s[32] != s[31]) begin
      sat_add = {1'b1, a[31] ? 32'h8000_0000 : 32'h7fff_ffff};
    end else begin
      sat_add = {1'b0, s[31:0]};
    end
  endfunction

  assign clearing = state == S_CLEAR;
  assign clr_last = clr_cnt == CLR_W'(CLR_DEPTH - 1);
  assign out_free = !out_valid || result.ready;
  assign finish = (state == S_RUN) && out_free;
  assign pop = q_valid && ((state == S_IDLE) || finish);
  assign item_we = finish && !r_cls.skip && !r_cls.pos_bad;

  // previous write to the same entry wins over the stale read
  assign tok_old = fwd_tok ? fwd_tok_val : tok_rd;
  assign pos_old = fwd_pos ? fwd_pos_val : pos_rd;
  assign tok_add = sat_add(tok_old, r_grad);
  assign pos_add = sat_add(pos_old, r_grad);

  always_comb begin
    if (clearing) begin
      tok_we = int'(clr_cnt) < TOK_DEPTH;
      pos_we = int'(clr_cnt) < POS_DEPTH;
      tok_wa = clr_cnt[TA_W-1:0];
      pos_wa = clr_cnt[PA_W-1:0];
      tok_wd = 32'd0;
      pos_wd = 32'd0;
    end else begin
      tok_we = item_we;
      pos_we = item_we;
      tok_wa = r_tok_addr;
      pos_wa = r_pos_addr;
      tok_wd = tok_add[31:0];
      pos_wd = pos_add[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (tok_we) tok_mem[tok_wa] <= tok_wd;
    if (pop) tok_rd <= tok_mem[q_tok_addr];
  end

  always_ff @(posedge clk) begin
    if (pos_we) pos_mem[pos_wa] <= pos_wd;
    if (pop) pos_rd <= pos_mem[q_pos_addr];
  end

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: if (clr_last) state_next = S_IDLE;
      S_IDLE: if (pop) state_next = S_RUN;
      S_RUN: if (finish && !pop) state_next = S_IDLE;
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (clearing) clr_cnt <= clr_cnt + CLR_W'(1);
      if (finish) out_valid <= 1'b1;
      else if (result.ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      r_cls <= q_cls;
      r_tok_addr <= q_tok_addr;
      r_pos_addr <= q_pos_addr;
      r_grad <= q_grad;
      fwd_tok <= item_we && (q_tok_addr == r_tok_addr);
      fwd_pos <= item_we && (q_pos_addr == r_pos_addr);
      fwd_tok_val <= tok_add[31:0];
      fwd_pos_val <= pos_add[31:0];
    end
    if (finish) begin
      out_done <= r_cls.last;
      if (r_cls.skip) begin
        out_tok <= 32'd0;
        out_pos <= 32'd0;
        out_status <= egsa_pkg::STATUS_SKIP;
      end else if (r_cls.pos_bad) begin
        out_tok <= tok_old;
        out_pos <= 32'd0;
        out_status <= egsa_pkg::STATUS_POS_RANGE;
      end else begin
        out_tok <= tok_add[31:0];
        out_pos <= pos_add[31:0];
        out_status <= (tok_add[32] || pos_add[32]) ? egsa_pkg::STATUS_SAT
                                                   : egsa_pkg::STATUS_OK;
      end
    end
  end

  assign result.valid = out_valid;
  assign result.token_grad_now = out_tok;
  assign result.pos_grad_now = out_pos;
  assign result.status = out_status;
  assign result.done_res = out_done;

endmodule
`default_nettype wire

// ----- src/embedding_grad_scatter_accumulate.sv -----
`default_nettype none
// channel   | dir | handshake         | payload
// ----------+-----+-------------------+----------------------------------------------
// item      | in  | valid / ready     | token_id, position, channel, grad, last_item
// result    | out | valid / ready     | token_grad_now, pos_grad_now, status, done_res
// cfg       | in  | cfg_we            | cfg_index, cfg_data (chans_in_use, seq_len)
//
// steady state one request per cycle unless result stalls: the back end reads both tables in the
// pop cycle and writes the saturated sums as it loads the result register, with a forward path for
// back-to-back hits; accepted requests pass the two-entry queue, the read registers and the result
// register; after reset both tables are zeroed one entry a cycle over max(VOCAB_ROWS, MAX_POSITIONS)
// times MAX_CHANNELS addresses (16384 at defaults), item.ready low meanwhile
// result stall holds the back end; the queue keeps the front taking requests until full
module embedding_grad_scatter_accumulate #(
  parameter int VOCAB_ROWS = 256,
  parameter int MAX_POSITIONS = 64,
  parameter int MAX_CHANNELS = 64
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_we,
  input  wire logic [egsa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [egsa_pkg::CFG_DATA_W-1:0] cfg_data,
  egsa_item_if.sink item,
  egsa_result_if.source result
);

  // table geometry: row-major, MAX_CHANNELS entries per row
  localparam int TOK_DEPTH = VOCAB_ROWS * MAX_CHANNELS;
  localparam int POS_DEPTH = MAX_POSITIONS * MAX_CHANNELS;
  localparam int TA_W = $clog2(TOK_DEPTH);
  localparam int PA_W = POS_DEPTH > 1 ? $clog2(POS_DEPTH) : 1;
  localparam int CLS_W = $bits(egsa_pkg::egsa_cls_t);
  localparam int QW = CLS_W + TA_W + PA_W + 32;

  // front side of the queue
  logic push;
  egsa_pkg::egsa_cls_t f_cls;
  logic [TA_W-1:0] f_tok_addr;
  logic [PA_W-1:0] f_pos_addr;
  logic [31:0] f_grad;

  // back side of the queue
  logic pop;
  logic q_full;
  logic q_valid;
  logic [QW-1:0] q_head;
  egsa_pkg::egsa_cls_t q_cls;
  logic [TA_W-1:0] q_tok_addr;
  logic [PA_W-1:0] q_pos_addr;
  logic [31:0] q_grad;

  logic clearing;

  // config registers, range checks and table addressing
  egsa_front #(
    .VOCAB_ROWS(VOCAB_ROWS),
    .MAX_POSITIONS(MAX_POSITIONS),
    .MAX_CHANNELS(MAX_CHANNELS),
    .TA_W(TA_W),
    .PA_W(PA_W)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .item(item),
    .q_full(q_full),
    .clearing(clearing),
    .push(push),
    .cls(f_cls),
    .tok_addr(f_tok_addr),
    .pos_addr(f_pos_addr),
    .grad(f_grad)
  );

  // classified requests wait here while the back end or the result side stalls
  egsa_queue #(
    .W(QW)
  ) u_queue (
    .clk(clk),
    .rst(rst),
    .push(push),
    .wdata({f_cls, f_tok_addr, f_pos_addr, f_grad}),
    .pop(pop),
    .rdata(q_head),
    .full(q_full),
    .not_empty(q_valid)
  );

  assign {q_cls, q_tok_addr, q_pos_addr, q_grad} = q_head;

  // table memories, read-modify-write with saturation, result register
  egsa_back #(
    .TOK_DEPTH(TOK_DEPTH),
    .POS_DEPTH(POS_DEPTH),
    .TA_W(TA_W),
    .PA_W(PA_W)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .q_valid(q_valid),
    .q_cls(q_cls),
    .q_tok_addr(q_tok_addr),
    .q_pos_addr(q_pos_addr),
    .q_grad(q_grad),
    .pop(pop),
    .clearing(clearing),
    .result(result)
  );

endmodule
`default_nettype wire
